// ===== sv/gtr_pkg.sv =====
// ---------------------------------------------------------------------------
// gtr_pkg
// Types, constants and the 5x7 font for the glyph rectangle generator.
// ---------------------------------------------------------------------------
package gtr_pkg;

  localparam int GLYPH_COLS       = 5;
  localparam int GLYPH_ROWS       = 7;
  localparam int GLYPH_BITS       = GLYPH_COLS * GLYPH_ROWS;
  localparam int JOB_QUEUE_DEPTH  = 2;
  localparam int OUT_QUEUE_DEPTH  = 2;

  localparam logic [8:0] SCREEN_LONG  = 9'd320;
  localparam logic [8:0] SCREEN_SHORT = 9'd240;
  localparam logic [2:0] ORIENT_RESET = 3'd3;

  // Sequencer index: 35 cells, then the spacing column
  localparam logic [5:0] IDX_LAST_CELL = 6'(GLYPH_BITS - 1);
  localparam logic [5:0] IDX_SPACING   = 6'(GLYPH_BITS);
  localparam logic [2:0] COL_LAST      = 3'(GLYPH_COLS - 1);

  typedef struct packed {
    logic        string_start;
    logic [15:0] start_x;
    logic [15:0] row_y;
    logic [7:0]  char_code;
    logic [15:0] ink_color;
    logic [15:0] paper_color;
    logic [7:0]  scale;
  } gtr_char_t;

  typedef struct packed {
    logic [8:0]  rect_x;
    logic [8:0]  rect_y;
    logic [8:0]  rect_width;
    logic [8:0]  rect_height;
    logic [15:0] fill_color;
    logic        drawn;
    logic        last;
  } gtr_rect_t;

  // One classified character handed from front to back
  typedef struct packed {
    logic [15:0]           cx;
    logic [15:0]           ry;
    logic [GLYPH_BITS-1:0] bitmap;  // top row in the MSBs, left column first
    logic [15:0]           fg;
    logic [15:0]           bg;
    logic [7:0]            sc;
  } gtr_job_t;

  function automatic logic [GLYPH_BITS-1:0] glyph_bitmap(input logic [7:0] code);
    logic [GLYPH_BITS-1:0] b;
    case (code)
      8'h2B: b = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
      8'h2D: b = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      8'h3A: b = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      8'h28: b = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
      8'h29: b = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
      8'h30: b = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      8'h31: b = {5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F};
      8'h32: b = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      8'h33: b = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h34: b = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      8'h35: b = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      8'h36: b = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      8'h37: b = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: b = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      8'h39: b = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C};
      8'h41: b = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8'h42: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      8'h43: b = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      8'h44: b = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h45: b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      8'h46: b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h47: b = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      8'h48: b = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8'h49: b = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h4B: b = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      8'h4C: b = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      8'h4D: b = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4E: b = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      8'h4F: b = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h50: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h52: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      8'h53: b = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h54: b = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: b = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h57: b = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      8'h59: b = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      default: b = '0;  // space and unknown codes are blank
    endcase
    return b;
  endfunction

endpackage

// ===== sv/glyph_text_rect_generator_unit.sv =====
// A character passes through the job queue, the back-end registers and the output queue.
// The back-end sequencer produces one rectangle per cycle while the output queue is not
//   full; a zero-scale character gives no results.
// Up to JOB_DEPTH characters queue between front and back.
// Reset: cursor 0, orientation 3, both queues empty.
// ---------------------------------------------------------------------------
// glyph_text_rect_generator_unit
// Scaled 5x7 text to clipped filled rectangles, 36 per character of nonzero scale.
// ---------------------------------------------------------------------------
module glyph_text_rect_generator_unit #(
  parameter int JOB_DEPTH = gtr_pkg::JOB_QUEUE_DEPTH,
  parameter int OUT_DEPTH = gtr_pkg::OUT_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_data,
  input  logic               push,
  output logic               full,
  input  gtr_pkg::gtr_char_t char_item,
  input  logic               pop,
  output logic               empty,
  output gtr_pkg::gtr_rect_t rect_item
);
  import gtr_pkg::*;

  logic      [2:0] orient;
  logic            job_push;
  logic            job_pop;
  logic            job_empty;
  gtr_job_t        job_in;
  gtr_job_t        job_out;
  logic            out_push;
  logic            out_full;
  gtr_rect_t       out_rect;

  always_ff @(posedge clk) begin
    if (rst) begin
      orient <= ORIENT_RESET;
    end else if (cfg_write) begin
      orient <= cfg_data;
    end
  end

  gtr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .char_item (char_item),
    .job_full  (full),
    .job_push  (job_push),
    .job       (job_in)
  );

  gtr_fifo #(
    .WIDTH ($bits(gtr_job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  gtr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .orient    (orient),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_rect  (out_rect)
  );

  gtr_fifo #(
    .WIDTH ($bits(gtr_rect_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_rect),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (rect_item),
    .empty   (empty)
  );

endmodule

// ===== sv/gtr_fifo.sv =====
// ---------------------------------------------------------------------------
// gtr_fifo
// Small register queue with wrapping pointers and a fill count.
// ---------------------------------------------------------------------------
module gtr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/gtr_front.sv =====
// ---------------------------------------------------------------------------
// gtr_front
// Accepts characters, tracks the cursor and looks up the glyph bitmap.
// ---------------------------------------------------------------------------
module gtr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gtr_pkg::gtr_char_t char_item,
  input  logic              job_full,
  output logic              job_push,
  output gtr_pkg::gtr_job_t  job
);
  import gtr_pkg::*;

  logic [15:0] cursor;
  logic [15:0] cx;
  logic [10:0] advance;
  logic        accept;

  assign accept  = push && !job_full;
  assign cx      = char_item.string_start ? char_item.start_x : cursor;
  // six times the scale
  assign advance = {1'b0, char_item.scale, 2'b00} + {2'b00, char_item.scale, 1'b0};

  // a zero scale only touches the cursor load
  assign job_push   = accept && (char_item.scale != '0);
  assign job.cx     = cx;
  assign job.ry     = char_item.row_y;
  assign job.bitmap = glyph_bitmap(char_item.char_code);
  assign job.fg     = char_item.ink_color;
  assign job.bg     = char_item.paper_color;
  assign job.sc     = char_item.scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (accept) begin
      cursor <= cx + {5'b0, advance};
    end
  end

endmodule

// ===== sv/gtr_back.sv =====
// ---------------------------------------------------------------------------
// gtr_back
// Walks the 35 glyph cells and the spacing column, clips each rectangle.
// ---------------------------------------------------------------------------
module gtr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         orient,
  input  logic               job_empty,
  input  gtr_pkg::gtr_job_t  job,
  output logic               job_pop,
  input  logic               out_full,
  output logic               out_push,
  output gtr_pkg::gtr_rect_t out_rect
);
  import gtr_pkg::*;

  logic                  busy;
  logic [5:0]            idx;
  logic [2:0]            col;
  logic [15:0]           x;
  logic [15:0]           y;
  logic [15:0]           cx;
  logic [15:0]           ry;
  logic [GLYPH_BITS-1:0] bits;
  logic [15:0]           fg;
  logic [15:0]           bg;
  logic [7:0]            sc;
  logic [10:0]           h7;

  logic        step;
  logic        spacing;
  logic [10:0] h;
  logic [8:0]  scr_w;
  logic [8:0]  scr_h;
  logic        on_screen;
  logic [9:0]  x_end;
  logic [11:0] y_end;

  assign step    = busy && !out_full;
  assign spacing = (idx == IDX_SPACING);
  assign job_pop = (!busy || (step && spacing)) && !job_empty;

  // clip against the selected screen
  assign scr_w     = orient[0] ? SCREEN_LONG : SCREEN_SHORT;
  assign scr_h     = orient[0] ? SCREEN_SHORT : SCREEN_LONG;
  assign h         = spacing ? h7 : {3'b0, sc};
  assign on_screen = (x < {7'b0, scr_w}) && (y < {7'b0, scr_h});
  assign x_end     = {1'b0, x[8:0]} + {2'b0, sc};
  assign y_end     = {3'b0, y[8:0]} + {1'b0, h};

  always_comb begin
    out_push = step;
    out_rect = '0;
    out_rect.last = spacing;
    if (on_screen) begin
      out_rect.rect_x      = x[8:0];
      out_rect.rect_y      = y[8:0];
      out_rect.rect_width  = (x_end > {1'b0, scr_w}) ? scr_w - x[8:0] : {1'b0, sc};
      out_rect.rect_height = (y_end > {3'b0, scr_h}) ? scr_h - y[8:0] : h[8:0];
      out_rect.fill_color  = (!spacing && bits[GLYPH_BITS-1]) ? fg : bg;
      out_rect.drawn       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cx   <= job.cx;
      ry   <= job.ry;
      x    <= job.cx;
      y    <= job.ry;
      bits <= job.bitmap;
      fg   <= job.fg;
      bg   <= job.bg;
      sc   <= job.sc;
      h7   <= {job.sc, 3'b000} - {3'b000, job.sc};
    end else if (step) begin
      bits <= {bits[GLYPH_BITS-2:0], 1'b0};
      if (col == COL_LAST && idx != IDX_LAST_CELL) begin
        x <= cx;
        y <= y + {8'b0, sc};
      end else begin
        x <= x + {8'b0, sc};
        if (idx == IDX_LAST_CELL) begin
          y <= ry;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      col  <= '0;
    end else if (job_pop) begin
      busy <= 1'b1;
      idx  <= '0;
      col  <= '0;
    end else if (step) begin
      if (spacing) begin
        busy <= 1'b0;
      end
      idx <= idx + 1'b1;
      col <= (col == COL_LAST) ? '0 : col + 1'b1;
    end
  end

endmodule

// ===== bench/glyph_text_rect_generator_unit_tb.sv =====
// ---------------------------------------------------------------------------
// glyph_text_rect_generator_unit_tb
// Sends text characters into the glyph rectangle generator and checks every
// rectangle against a predictor of the font, cursor and clipping rules.
// The scan mode changes between phases, with random gaps on both sides.
// ---------------------------------------------------------------------------
module glyph_text_rect_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gtr_pkg::*;

  localparam int FONT_SIZE = 37;
  localparam int LONG_HOLD = 500;

  // Glyph order matches the row table below; the first entry is the blank
  localparam logic [FONT_SIZE*8-1:0] FONT_CODES = " +-:()0123456789ABCDEFGHIKLMNOPRSTUWY";
  localparam logic [FONT_SIZE*35-1:0] FONT_ROWS = {
    5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00,  // space
    5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00,  // +
    5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00,  // -
    5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00,  // :
    5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02,  // (
    5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08,  // )
    5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E,  // 0
    5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F,  // 1
    5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F,  // 2
    5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E,  // 3
    5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02,  // 4
    5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E,  // 5
    5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E,  // 6
    5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08,  // 7
    5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E,  // 8
    5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C,  // 9
    5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11,  // A
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E,  // B
    5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E,  // C
    5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E,  // D
    5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F,  // E
    5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10,  // F
    5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E,  // G
    5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11,  // H
    5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E,  // I
    5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11,  // K
    5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F,  // L
    5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11,  // M
    5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11,  // N
    5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E,  // O
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10,  // P
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11,  // R
    5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E,  // S
    5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04,  // T
    5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E,  // U
    5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A,  // W
    5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04   // Y
  };

  logic      clk;
  logic      rst = 1'b1;
  logic      cfg_write = 1'b0;
  logic [2:0] cfg_data = '0;
  logic      push = 1'b0;
  logic      full;
  gtr_char_t char_item = '0;
  logic      pop = 1'b0;
  logic      empty;
  gtr_rect_t rect_item;

  gtr_char_t   chars_to_send[$];
  gtr_rect_t   rects_due[$];
  logic [2:0]  screen_mode = ORIENT_RESET;
  logic [15:0] cursor_col = '0;

  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int chars_queued = 0;
  int chars_accepted = 0;
  int rects_checked = 0;
  int rects_drawn = 0;
  int full_stalls = 0;
  int errors = 0;

  glyph_text_rect_generator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .char_item (char_item),
    .pop       (pop),
    .empty     (empty),
    .rect_item (rect_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic logic [4:0] glyph_row(logic [7:0] code, int row);
    int g;
    g = 0;  // unknown codes fall back to the blank glyph
    for (int i = 0; i < FONT_SIZE; i++)
      if (FONT_CODES[(FONT_SIZE - 1 - i) * 8 +: 8] == code) g = i;
    return FONT_ROWS[(FONT_SIZE - 1 - g) * 35 + (GLYPH_ROWS - 1 - row) * 5 +: 5];
  endfunction

  function automatic gtr_rect_t clip_rect(logic [15:0] x, logic [15:0] y, int unsigned w,
                                          int unsigned h, logic [15:0] color, logic is_last);
    int unsigned sw, sh;
    gtr_rect_t r;
    sw = 32'(screen_mode[0] ? SCREEN_LONG : SCREEN_SHORT);
    sh = 32'(screen_mode[0] ? SCREEN_SHORT : SCREEN_LONG);
    r = '0;
    if (x < sw && y < sh && w != 0 && h != 0) begin
      if (x + w > sw) w = sw - x;
      if (y + h > sh) h = sh - y;
      r.rect_x      = x[8:0];
      r.rect_y      = y[8:0];
      r.rect_width  = 9'(w);
      r.rect_height = 9'(h);
      r.fill_color  = color;
      r.drawn       = 1'b1;
    end
    r.last = is_last;
    return r;
  endfunction

  function automatic void draw_char_rects(gtr_char_t c);
    logic [15:0] cx;
    logic [4:0]  bits;
    if (c.string_start) cursor_col = c.start_x;
    if (c.scale == 0) return;
    cx = cursor_col;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      bits = glyph_row(c.char_code, r);
      for (int k = 0; k < GLYPH_COLS; k++)
        rects_due.push_back(clip_rect(16'(cx + k * c.scale), 16'(c.row_y + r * c.scale),
                                      32'(c.scale), 32'(c.scale),
                                      bits[GLYPH_COLS - 1 - k] ? c.ink_color : c.paper_color,
                                      1'b0));
    end
    // spacing column on the right of the glyph
    rects_due.push_back(clip_rect(16'(cx + GLYPH_COLS * c.scale), c.row_y, 32'(c.scale),
                                  GLYPH_ROWS * c.scale, c.paper_color, 1'b1));
    cursor_col = 16'(cx + (GLYPH_COLS + 1) * c.scale);
  endfunction

  function automatic void check_rect(gtr_rect_t got);
    gtr_rect_t want;
    if (rects_due.size() == 0) begin
      $error("rectangle with none expected: x=%0d y=%0d", got.rect_x, got.rect_y);
      errors++;
      return;
    end
    want = rects_due.pop_front();
    rects_checked++;
    if (want.drawn) rects_drawn++;
    if (got.rect_x !== want.rect_x) begin
      $error("rect_x expected %0d got %0d", want.rect_x, got.rect_x); errors++;
    end
    if (got.rect_y !== want.rect_y) begin
      $error("rect_y expected %0d got %0d", want.rect_y, got.rect_y); errors++;
    end
    if (got.rect_width !== want.rect_width) begin
      $error("rect_width expected %0d got %0d", want.rect_width, got.rect_width); errors++;
    end
    if (got.rect_height !== want.rect_height) begin
      $error("rect_height expected %0d got %0d", want.rect_height, got.rect_height); errors++;
    end
    if (got.fill_color !== want.fill_color) begin
      $error("fill_color expected %h got %h", want.fill_color, got.fill_color); errors++;
    end
    if (got.drawn !== want.drawn) begin
      $error("drawn expected %0b got %0b", want.drawn, got.drawn); errors++;
    end
    if (got.last !== want.last) begin
      $error("last expected %0b got %0b", want.last, got.last); errors++;
    end
  endfunction

  // ---------------- driver and monitor ----------------

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && full) begin
      full_stalls++;
    end else begin
      if (push) begin
        draw_char_rects(char_item);
        chars_accepted++;
      end
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (chars_to_send.size() == 0) begin
        push <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 14);
        push <= 1'b0;
      end else begin
        char_item <= chars_to_send.pop_front();
        push <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_rect(rect_item);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        recv_gap = LONG_HOLD;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 14);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic add_char(logic ss, logic [15:0] sx, logic [15:0] y, logic [7:0] code,
                          logic [15:0] fg, logic [15:0] bg, logic [7:0] sc);
    gtr_char_t c;
    c.string_start = ss;
    c.start_x      = sx;
    c.row_y        = y;
    c.char_code    = code;
    c.ink_color    = fg;
    c.paper_color  = bg;
    c.scale        = sc;
    chars_to_send.push_back(c);
    chars_queued++;
  endtask

  // Every accepted character has its rectangles; zero-scale ones give none
  task automatic drain_results();
    while (chars_accepted != chars_queued || rects_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_orient(logic [2:0] m);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    screen_mode = m;
  endtask

  task automatic queue_corners();
    logic [15:0] sw, sh;
    sw = 16'(screen_mode[0] ? SCREEN_LONG : SCREEN_SHORT);
    sh = 16'(screen_mode[0] ? SCREEN_SHORT : SCREEN_LONG);
    add_char(1'b1, sw - 1, sh - 1, "8", 16'hF800, 16'h07E0, 8'd1);  // only the corner cell
    add_char(1'b1, sw, 16'd0, "B", 16'h001F, 16'hFFFF, 8'd1);        // right of screen
    add_char(1'b1, 16'd0, sh, "C", 16'hFFFF, 16'h001F, 8'd1);        // below screen
    add_char(1'b1, sw - 7, sh - 10, "M", 16'h1234, 16'hABCD, 8'd3);  // cut at both edges
  endtask

  function automatic logic [15:0] random_coord();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'(65536 - $urandom_range(1, 300));
      default: return 16'($urandom_range(0, 330));
    endcase
  endfunction

  function automatic logic [7:0] random_scale();
    case ($urandom_range(0, 19))
      0: return 8'd0;
      1: return 8'($urandom_range(41, 255));
      2, 3: return 8'($urandom_range(5, 40));
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [7:0] random_code();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return FONT_CODES[$urandom_range(0, FONT_SIZE - 1) * 8 +: 8];
  endfunction

  function automatic gtr_char_t random_char();
    gtr_char_t c;
    c.string_start = 1'($urandom);
    c.start_x      = random_coord();
    c.row_y        = random_coord();
    c.char_code    = random_code();
    c.ink_color    = 16'($urandom);
    c.paper_color  = 16'($urandom);
    c.scale        = random_scale();
    return c;
  endfunction

  // Mostly strings: a start character, then followers on the same line
  task automatic queue_text(int n);
    gtr_char_t c;
    int len;
    while (n > 0) begin
      len = $urandom_range(1, 8);
      c = random_char();
      c.string_start = 1'b1;
      for (int i = 0; i < len && n > 0; i++) begin
        if (i > 0) begin
          c.string_start = ($urandom_range(0, 15) == 0);
          c.start_x      = 16'($urandom);
          c.char_code    = random_code();
          if ($urandom_range(0, 5) == 0) c.scale = random_scale();
          if ($urandom_range(0, 9) == 0) c = random_char();  // noise
        end
        add_char(c.string_start, c.start_x, c.row_y, c.char_code, c.ink_color,
                 c.paper_color, c.scale);
        n--;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: zero scale, blank and unknown codes, wraparound, huge scale
    add_char(1'b1, 16'd10, 16'd5, "A", 16'hFFFF, 16'h0000, 8'd0);
    add_char(1'b0, 16'hFFFF, 16'd5, "A", 16'hFFFF, 16'h0000, 8'd1);
    add_char(1'b0, 16'h0000, 16'd5, "8", 16'h0000, 16'hFFFF, 8'd2);
    add_char(1'b0, 16'h5555, 16'd5, 8'h00, 16'hAAAA, 16'h5555, 8'd1);
    add_char(1'b0, 16'hAAAA, 16'd5, 8'hFF, 16'h5555, 16'hAAAA, 8'd3);
    add_char(1'b0, 16'd0, 16'd5, " ", 16'hFFFF, 16'h1111, 8'd1);
    add_char(1'b0, 16'd0, 16'd30, "W", 16'h2222, 16'h3333, 8'd0);
    add_char(1'b0, 16'd0, 16'd30, "K", 16'h2222, 16'h3333, 8'd2);
    add_char(1'b1, 16'd0, 16'd0, "W", 16'h0000, 16'hFFFF, 8'd255);
    add_char(1'b1, 16'hFFFF, 16'd10, "0", 16'h07E0, 16'hF800, 8'd2);
    add_char(1'b1, 16'd5, 16'hFFFF, "1", 16'hF800, 16'h07E0, 8'd1);
    add_char(1'b1, 16'hFFFA, 16'hFFFA, "Y", 16'h8001, 16'h7FFE, 8'd255);
    add_char(1'b1, 16'hFFF0, 16'd50, "(", 16'h4321, 16'h8765, 8'd4);
    add_char(1'b0, 16'd0, 16'd50, ":", 16'h4321, 16'h8765, 8'd2);
    add_char(1'b1, 16'd100, 16'd100, 8'h80, 16'hFFFF, 16'h0000, 8'd1);
    add_char(1'b0, 16'd0, 16'd100, "-", 16'hFFFF, 16'h0000, 8'd128);
    add_char(1'b1, 16'd200, 16'd120, ")", 16'hFFFF, 16'h0000, 8'd6);
    queue_corners();

    set_orient(3'd0);
    queue_corners();
    queue_text(100);

    // receiver holds off while the sender keeps offering, so the input backs up
    set_orient(3'd7);
    long_hold_req = 1'b1;
    queue_text(110);

    set_orient(3'd2);
    queue_text(100);

    set_orient(3'd5);
    idle_on = 1'b0;
    queue_text(100);

    drain_results();
    $display("Checked %0d characters giving %0d rectangles (%0d drawn) in scan modes 3 0 7 2 5.",
             chars_accepted, rects_checked, rects_drawn);
    $display("Input held off by full for %0d cycles.", full_stalls);
    if (errors == 0 && rects_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gtr_pkg.sv
sv/gtr_fifo.sv
sv/gtr_front.sv
sv/gtr_back.sv
sv/glyph_text_rect_generator_unit.sv
bench/glyph_text_rect_generator_unit_tb.sv
